// ===== rtl/core/ffba_pkg.sv =====
// shared types and constants for the first-fit block allocator
package ffba_pkg;

  localparam int ADDR_W = 24;  // user address and free address field width
  localparam int SIZE_W = 24;  // request and recorded block size width
  localparam int BASE_W = 25;  // heap offset, can reach one past the top of a 24-bit space
  localparam int HDR_W  = 7;   // header bytes, up to 127

  localparam int MAX_BLOCKS_DEF   = 32;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int ADDR_BITS_DEF    = 24;

  localparam logic [SIZE_W-1:0] HEAP_LIMIT_RST = '1;

  typedef enum logic [2:0] {
    ST_NEW          = 3'd0,
    ST_REUSED       = 3'd1,
    ST_FREED        = 3'd2,
    ST_ALLOC_FAIL   = 3'd3,
    ST_FREE_UNKNOWN = 3'd4
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_ROTATE = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } entry_t;

  // ins is the new entry on a push and the returning head entry on a rotate
  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } chain_ctrl_t;

endpackage

// ===== rtl/core/ffba_cell.sv =====
// one block descriptor cell of the allocator chain
module ffba_cell (
  input  logic              clk,
  input  ffba_pkg::cell_op_t op,
  input  logic              is_tail,
  input  ffba_pkg::entry_t  lower_in,
  input  ffba_pkg::entry_t  upper_in,
  input  ffba_pkg::entry_t  wrap_in,
  output ffba_pkg::entry_t  entry_out
);
  import ffba_pkg::*;

  entry_t entry_r, entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (op)
      OP_PUSH:   entry_nxt = lower_in;
      // the last occupied cell takes the head back so the ring closes
      OP_ROTATE: entry_nxt = is_tail ? wrap_in : upper_in;
      default:   entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_out = entry_r;

endmodule

// ===== rtl/core/ffba_chain.sv =====
// row of descriptor cells, newest entry at cell 0
module ffba_chain #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                  clk,
  input  ffba_pkg::chain_ctrl_t ctrl,
  input  logic [CNT_W-1:0]      count,
  output ffba_pkg::entry_t      head
);
  import ffba_pkg::*;

  entry_t cell_q [MAX_BLOCKS];

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    entry_t lower_w;
    entry_t upper_w;

    if (i == 0) begin : g_first
      assign lower_w = ctrl.ins;
    end else begin : g_mid_lo
      assign lower_w = cell_q[i-1];
    end

    if (i == MAX_BLOCKS - 1) begin : g_last
      assign upper_w = ctrl.ins;
    end else begin : g_mid_hi
      assign upper_w = cell_q[i+1];
    end

    ffba_cell u_cell (
      .clk       (clk),
      .op        (ctrl.op),
      .is_tail   (count == CNT_W'(i + 1)),
      .lower_in  (lower_w),
      .upper_in  (upper_w),
      .wrap_in   (ctrl.ins),
      .entry_out (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

// ===== rtl/core/first_fit_block_allocator_top.sv =====
// first-fit block allocator: control, heap pointer and the descriptor chain
//
// Requests arrive on the in_ channel (valid/ready): in_action selects allocate
// or free, in_request_size and in_free_address carry the operands. Each request
// gives exactly one result transfer on the out_ channel (valid/ready) with
// out_user_address, out_status and out_block_bytes.
// The user must write the heap limit through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block does not enforce this. It takes effect at once.
// The descriptors sit in a ring of cells with the newest at the head. A request
// rotates the occupied part of the ring once, one cell per cycle, checking the
// head cell; the first hit on the way is marked and later ones ignored.
// From the input transfer a request passes through the ring walk (S_SCAN, skipped
// on an empty table) and the decision step (S_DECIDE) into the output register;
// in_ready is high only in S_IDLE, so a new request is taken only after the
// decision step of the last one.
// A finished result waits in the output register; the block takes the next
// request meanwhile, but holds its decision step until out_ready has freed the
// register.
// Synchronous reset empties the table, clears the heap top and sets the heap
// limit to all ones; no clearing pass is needed.
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_BITS    = ffba_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ffba_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [ffba_pkg::SIZE_W-1:0] in_request_size,
  input  logic [ffba_pkg::ADDR_W-1:0] in_free_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ffba_pkg::ADDR_W-1:0] out_user_address,
  output logic [2:0]                  out_status,
  output logic [ffba_pkg::SIZE_W-1:0] out_block_bytes
);
  import ffba_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W = BASE_W + 1;
  localparam int CHK_W = (ADDR_BITS > SUM_W) ? ADDR_BITS + 1 : SUM_W + 1;
  localparam logic [HDR_W-1:0] HDR = HDR_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0] HDR_SUM = {{(SUM_W - HDR_W){1'b0}}, HDR};
  localparam logic [CHK_W-1:0] HDR_CHK = {{(CHK_W - HDR_W){1'b0}}, HDR};
  localparam logic [CHK_W-1:0] ADDR_MAX = {CHK_W{1'b1}} >> (CHK_W - ADDR_BITS);

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_DECIDE = 2'd2
  } state_t;

  state_t            state_r, state_nxt;
  action_t           action_r, action_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              found_r, found_nxt;
  logic [BASE_W-1:0] fbase_r, fbase_nxt;
  logic [SIZE_W-1:0] fsize_r, fsize_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BASE_W-1:0] heap_top_r, heap_top_nxt;
  logic [SIZE_W-1:0] heap_limit_r, heap_limit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_ua_r, out_ua_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SIZE_W-1:0] out_bytes_r, out_bytes_nxt;

  chain_ctrl_t       ctrl;
  entry_t            head;
  logic [SUM_W-1:0]  head_ua;
  logic              hit;
  logic [SUM_W-1:0]  new_end;
  logic [SUM_W-1:0]  limit_p1;
  logic [CHK_W-1:0]  new_ua_chk;
  logic              new_ok;
  logic              out_free;

  ffba_chain #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .CNT_W      (CNT_W)
  ) u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .count (count_r),
    .head  (head)
  );

  assign head_ua    = {1'b0, head.base} + HDR_SUM;
  assign new_end    = {1'b0, heap_top_r} + {{(SUM_W - SIZE_W){1'b0}}, req_r} + HDR_SUM;
  assign limit_p1   = {{(SUM_W - SIZE_W){1'b0}}, heap_limit_r} + SUM_W'(1);
  assign new_ua_chk = {{(CHK_W - BASE_W){1'b0}}, heap_top_r} + HDR_CHK;
  assign new_ok     = (count_r != CNT_W'(MAX_BLOCKS)) && (new_end <= limit_p1)
                      && (new_ua_chk <= ADDR_MAX);
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    if (found_r) begin
      hit = 1'b0;
    end else if (action_r == ACT_FREE) begin
      hit = (head_ua == {{(SUM_W - ADDR_W){1'b0}}, addr_r});
    end else begin
      hit = head.is_free && (head.size >= req_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    scan_nxt       = scan_r;
    found_nxt      = found_r;
    fbase_nxt      = fbase_r;
    fsize_nxt      = fsize_r;
    count_nxt      = count_r;
    heap_top_nxt   = heap_top_r;
    heap_limit_nxt = cfg_wr_en ? cfg_wr_data : heap_limit_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_ua_nxt     = out_ua_r;
    out_status_nxt = out_status_r;
    out_bytes_nxt  = out_bytes_r;
    ctrl.op        = OP_HOLD;
    ctrl.ins       = head;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt = action_t'(in_action);
          req_nxt    = in_request_size;
          addr_nxt   = in_free_address;
          scan_nxt   = '0;
          found_nxt  = 1'b0;
          state_nxt  = (count_r == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.op = OP_ROTATE;
        if (hit) begin
          ctrl.ins.is_free = (action_r == ACT_FREE);
          found_nxt        = 1'b1;
          fbase_nxt        = head.base;
          fsize_nxt        = head.size;
        end
        scan_nxt = scan_r + CNT_W'(1);
        if (scan_r == count_r - CNT_W'(1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_ua_nxt    = '0;
          out_bytes_nxt = '0;
          if (action_r == ACT_FREE) begin
            out_status_nxt = found_r ? ST_FREED : ST_FREE_UNKNOWN;
            out_bytes_nxt  = found_r ? fsize_r : '0;
          end else if (found_r) begin
            out_status_nxt = ST_REUSED;
            out_ua_nxt     = ADDR_W'(fbase_r + BASE_W'(HEADER_BYTES));
            out_bytes_nxt  = fsize_r;
          end else if (new_ok) begin
            // carve a new block at the heap top and push it as newest
            ctrl.op          = OP_PUSH;
            ctrl.ins.base    = heap_top_r;
            ctrl.ins.size    = req_r;
            ctrl.ins.is_free = 1'b0;
            count_nxt        = count_r + CNT_W'(1);
            heap_top_nxt     = new_end[BASE_W-1:0];
            out_status_nxt   = ST_NEW;
            out_ua_nxt       = new_ua_chk[ADDR_W-1:0];
            out_bytes_nxt    = req_r;
          end else begin
            out_status_nxt = ST_ALLOC_FAIL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      heap_top_r   <= '0;
      heap_limit_r <= HEAP_LIMIT_RST;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      scan_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      heap_top_r   <= heap_top_nxt;
      heap_limit_r <= heap_limit_nxt;
      out_valid_r  <= out_valid_nxt;
      found_r      <= found_nxt;
      scan_r       <= scan_nxt;
    end
    action_r     <= action_nxt;
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    fbase_r      <= fbase_nxt;
    fsize_r      <= fsize_nxt;
    out_ua_r     <= out_ua_nxt;
    out_status_r <= out_status_nxt;
    out_bytes_r  <= out_bytes_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_user_address = out_ua_r;
  assign out_status       = out_status_r;
  assign out_block_bytes  = out_bytes_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCKS))
    else $error("descriptor count beyond table size");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_r < count_r))
    else $error("ring walk past the occupied cells");

  a_table_changes_on_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DECIDE) |=> ($stable(count_r) && $stable(heap_top_r)))
    else $error("table or heap top moved outside the decision step");

  a_heap_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |=> (heap_top_r >= $past(heap_top_r)))
    else $error("heap top went backwards");

endmodule

// ===== sim/tb_top.sv =====
// testbench for the first-fit block allocator: predicts each reply and checks it field by field
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  localparam int HDR = HEADER_BYTES_DEF;
  localparam int SLOTS = MAX_BLOCKS_DEF;
  localparam longint unsigned ADDR_LIMIT = (64'd1 << ADDR_BITS_DEF) - 1;
  localparam int IDLE_PCT = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 305;
  localparam logic [SIZE_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [ADDR_W-1:0] user_address;
    status_t           status;
    logic [SIZE_W-1:0] block_bytes;
  } reply_t;

  class block_table_predictor;
    logic [BASE_W-1:0] blk_base [SLOTS];
    logic [SIZE_W-1:0] blk_size [SLOTS];
    bit                blk_free [SLOTS];
    int unsigned       blk_count;
    logic [BASE_W-1:0] heap_top;
    logic [SIZE_W-1:0] heap_limit;
    reply_t            expected_replies [$];
    int                errors;

    function new();
      heap_limit = HEAP_LIMIT_RST;
      heap_top = '0;
      blk_count = 0;
      errors = 0;
      foreach (blk_free[i]) blk_free[i] = 1'b0;
    endfunction

    function void set_heap_limit(logic [SIZE_W-1:0] value);
      heap_limit = value;
    endfunction

    function logic [ADDR_W-1:0] user_address_of(int unsigned idx);
      return ADDR_W'(blk_base[idx] + HDR);
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void note_request(action_t act, logic [SIZE_W-1:0] req,
                               logic [ADDR_W-1:0] addr);
      reply_t r;
      longint unsigned block_end;
      bit done;
      r = '{'0, ST_ALLOC_FAIL, '0};
      done = 1'b0;
      if (act == ACT_ALLOC) begin
        // newest entry first
        for (int k = int'(blk_count) - 1; k >= 0; k--) begin
          if (blk_free[k] && blk_size[k] >= req) begin
            blk_free[k] = 1'b0;
            r = '{user_address_of(k), ST_REUSED, blk_size[k]};
            done = 1'b1;
            break;
          end
        end
        if (!done && blk_count < SLOTS) begin
          block_end = 64'(heap_top) + 64'(req) + HDR;
          if (block_end <= 64'(heap_limit) + 1 && 64'(heap_top) + HDR <= ADDR_LIMIT) begin
            blk_base[blk_count] = heap_top;
            blk_size[blk_count] = req;
            blk_free[blk_count] = 1'b0;
            r = '{user_address_of(blk_count), ST_NEW, req};
            blk_count++;
            heap_top = BASE_W'(block_end);
          end
        end
      end else begin
        r.status = ST_FREE_UNKNOWN;
        for (int k = int'(blk_count) - 1; k >= 0; k--) begin
          if (64'(blk_base[k]) + HDR == 64'(addr)) begin
            blk_free[k] = 1'b1;
            r = '{'0, ST_FREED, blk_size[k]};
            break;
          end
        end
      end
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [ADDR_W-1:0] addr, logic [2:0] st,
                              logic [SIZE_W-1:0] bytes);
      reply_t exp;
      if (expected_replies.size() == 0) begin
        errors++;
        $error("unexpected reply: user_address %0d status %0d block_bytes %0d",
               addr, st, bytes);
        return;
      end
      exp = expected_replies.pop_front();
      if (addr !== exp.user_address) begin
        errors++;
        $error("user_address: expected %0d, actual %0d", exp.user_address, addr);
      end
      if (st !== exp.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", exp.status, st);
      end
      if (bytes !== exp.block_bytes) begin
        errors++;
        $error("block_bytes: expected %0d, actual %0d", exp.block_bytes, bytes);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_action = ACT_ALLOC;
  logic [SIZE_W-1:0] in_request_size = '0;
  logic [ADDR_W-1:0] in_free_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] out_user_address;
  logic [2:0]        out_status;
  logic [SIZE_W-1:0] out_block_bytes;

  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;
  bit hold_off_start = 1'b0;
  int stalled_cycles = 0;

  block_table_predictor tracker = new();

  first_fit_block_allocator_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_request_size  (in_request_size),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_user_address (out_user_address),
    .out_status       (out_status),
    .out_block_bytes  (out_block_bytes)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_request(action_t act, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] addr);
    while (send_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_request_size <= req;
    in_free_address <= addr;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(act, req, addr);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // register writes only with the block idle
  task automatic set_heap_limit(logic [SIZE_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    tracker.set_heap_limit(value);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] limit_above_top(int margin);
    longint unsigned lim;
    lim = 64'(tracker.heap_top) + margin;
    return (lim > 64'(ALL_ONES)) ? ALL_ONES : SIZE_W'(lim);
  endfunction

  task automatic run_random_phase(int n, bit hold_off, bit pause);
    action_t           act;
    logic [SIZE_W-1:0] req;
    logic [ADDR_W-1:0] addr;
    int unsigned       pick;
    int unsigned       roll;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        if (hold_off) hold_off_start = 1'b1;
        if (pause) wait_drained();
      end
      act  = ACT_FREE;
      req  = SIZE_W'($urandom());
      addr = ADDR_W'($urandom());
      pick = (tracker.blk_count > 0) ? $urandom_range(tracker.blk_count - 1) : 0;
      roll = $urandom_range(99);
      if (roll < 50) begin
        act  = ACT_ALLOC;
        roll = $urandom_range(99);
        // sizes around a recorded block hit the fit boundary
        if (tracker.blk_count > 0 && roll < 20)
          req = SIZE_W'(tracker.blk_size[pick] + $urandom_range(2) - 1);
        else if (roll < 75)
          req = SIZE_W'($urandom_range(255));
        else if (roll < 95)
          req = SIZE_W'($urandom_range(4095));
      end else if (tracker.blk_count > 0 && roll < 88) begin
        addr = tracker.user_address_of(pick);
      end else if (tracker.blk_count > 0 && roll < 94) begin
        addr = ADDR_W'(tracker.user_address_of(pick) + $urandom_range(1, 2 * HDR));
      end
      send_request(act, req, addr);
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        tracker.check_reply(out_user_address, out_status, out_block_bytes);
      if (hold_off_start) begin
        hold_off_start = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(recv_idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_heap_limit(ALL_ONES);

    send_request(ACT_FREE, ALL_ONES, '0);   // free on an empty table
    send_request(ACT_ALLOC, '0, ALL_ONES);  // zero-byte block at user address 24
    send_request(ACT_ALLOC, 24'd100, '0);   // user address 48
    send_request(ACT_FREE, '0, 24'd48);
    send_request(ACT_FREE, '0, 24'd48);     // double free
    send_request(ACT_ALLOC, 24'd50, '0);    // reuse keeps the full 100 bytes
    send_request(ACT_FREE, '0, 24'd24);
    send_request(ACT_ALLOC, '0, '0);        // zero bytes fit the empty block
    send_request(ACT_FREE, '0, ALL_ONES);
    send_request(ACT_ALLOC, ALL_ONES, '0);  // heap exhausted
    send_request(ACT_FREE, '0, 24'd47);     // one short of a live address
    send_request(ACT_FREE, '0, 24'd24);
    send_request(ACT_FREE, '0, 24'd48);
    send_request(ACT_ALLOC, '0, '0);        // newest free block wins
    send_request(ACT_ALLOC, '0, '0);

    // room for exactly ten more bytes
    set_heap_limit(limit_above_top(HDR + 10 - 1));
    send_request(ACT_ALLOC, 24'd10, '0);
    send_request(ACT_ALLOC, '0, '0);
    set_heap_limit('0);
    send_request(ACT_ALLOC, '0, '0);
    send_request(ACT_FREE, '0, 24'd172);
    send_request(ACT_ALLOC, 24'd5, '0);

    // the heap top only grows, so this run fills the table rather than
    // pushing a user address past the top of the address space
    set_heap_limit(limit_above_top(6000));
    run_random_phase(PHASE_ITEMS, 1'b1, 1'b0);
    set_heap_limit('0);
    run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    set_heap_limit(SIZE_W'($urandom_range(0, ALL_ONES)));
    run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    set_heap_limit(ALL_ONES);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    set_heap_limit(limit_above_top(500));
    run_random_phase(PHASE_ITEMS, 1'b0, 1'b1);
    set_heap_limit(ALL_ONES);
    run_random_phase(PHASE_ITEMS, 1'b1, 1'b0);

    wait_drained();
    repeat (SLOTS + 4) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/ffba_pkg.sv
rtl/core/ffba_cell.sv
rtl/core/ffba_chain.sv
rtl/core/first_fit_block_allocator_top.sv
sim/tb_top.sv
